// ----- rtl/rmie_pkg.sv -----
// Package for the real-mode instruction executor.
// Holds request, opcode, status, port-access, config-index and register-index codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmie_pkg;
    typedef enum logic [1:0] {
        REQ_EXEC  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [4:0] {
        OP_NOP = 5'd0, OP_HLT = 5'd1, OP_IN = 5'd2, OP_OUT = 5'd3,
        OP_MOV = 5'd4, OP_PUSH = 5'd5, OP_POP = 5'd6, OP_JMP = 5'd7,
        OP_RET = 5'd8, OP_INT = 5'd9, OP_IRET = 5'd10, OP_STOSB = 5'd11,
        OP_INC = 5'd12, OP_DEC = 5'd13, OP_CMP = 5'd14, OP_JZ = 5'd15,
        OP_JNZ = 5'd16
    } t_op;

    localparam logic [4:0] OP_LAST = 5'd16;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_HALTED  = 2'd2;

    localparam logic [1:0] PA_NONE  = 2'd0;
    localparam logic [1:0] PA_READ  = 2'd1;
    localparam logic [1:0] PA_WRITE = 2'd2;

    localparam logic [2:0] CFG_SS  = 3'd0;
    localparam logic [2:0] CFG_ES  = 3'd1;
    localparam logic [2:0] CFG_CS0 = 3'd2;
    localparam logic [2:0] CFG_IP0 = 3'd3;
    localparam logic [2:0] CFG_SP0 = 3'd4;

    localparam logic [2:0] REG_AX = 3'd0;
    localparam logic [2:0] REG_SP = 3'd4;
    localparam logic [2:0] REG_DI = 3'd7;
    localparam int         ZF_POS = 6;
endpackage
`default_nettype wire

// ----- rtl/real_mode_instruction_executor.sv -----
// Real-mode instruction executor top level: register file, sequencer and guest RAM.
// Depends on rmie_pkg for its codes.
//
// Use: an item (execute, RAM byte write or RAM byte read) transfers on the input
// channel when i_valid is high and o_stall low. The block then works on it alone;
// o_stall stays high until its single result has transferred on the output
// channel (o_valid high, i_stall low). Every RAM byte goes through one
// single-port memory in S_MEM (address), then S_WAIT (registered data), and
// one shared 32-bit adder forms each base address, byte address step and jump
// target; stack pointer updates use their own arithmetic. An item passes
// through S_ADDR, then S_MEM and S_WAIT once per RAM byte touched, then
// S_FINISH and S_OUT: no bytes for register-only opcodes, one for RAM requests
// and STOSB, two for RET, four for PUSH/POP, six for IRET and ten for INT. A
// stalled result holds steady in S_OUT; after its transfer the block is idle again.
// Configuration writes are taken in any cycle (o_cfg_ready is tied high) and
// must only be issued while the block is idle. Synchronous reset clears the
// registers, loads the start values (all zero after reset) and leaves the RAM
// contents undefined; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module real_mode_instruction_executor
    import rmie_pkg::*;
#(
    parameter int RAM_BYTES = 65536
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_req_type,
    input  wire  [4:0]  i_opcode,
    input  wire  signed [3:0] i_dest_register,
    input  wire         i_source_is_register,
    input  wire  [31:0] i_immediate,
    input  wire  [3:0]  i_instr_length,
    input  wire  [7:0]  i_port_read_data,
    input  wire  [15:0] i_ram_address,
    input  wire  [7:0]  i_ram_write_byte,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [1:0]  o_status,
    output logic        o_is_halted,
    output logic [31:0] o_ip_out,
    output logic [15:0] o_cs_out,
    output logic        o_zero_flag,
    output logic [1:0]  o_port_access,
    output logic [15:0] o_port_number,
    output logic [7:0]  o_port_write_data,
    output logic [7:0]  o_ram_read_byte,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
    localparam int AW = $clog2(RAM_BYTES);

    typedef enum logic [2:0] {
        S_IDLE, S_ADDR, S_MEM, S_WAIT, S_FINISH, S_OUT
    } t_state;

    // Sequencer state and architectural registers.
    t_state      r_state;
    logic [31:0] r_gr [8];
    logic [31:0] r_ip, r_flags;
    logic [15:0] r_cs, r_ss, r_es;
    logic        r_halt;

    // Latched item.
    logic [1:0]  r_req;
    logic [4:0]  r_op;
    logic        r_dvalid;
    logic [2:0]  r_dst;
    logic        r_srcreg;
    logic [31:0] r_imm;
    logic [3:0]  r_len;
    logic [7:0]  r_pdata;
    logic [15:0] r_raddr;
    logic [7:0]  r_wbyte;

    // Sequencer: byte counter, byte total, data word, write flag and address.
    logic [3:0]  r_cnt;      // byte index within whole operation
    logic [3:0]  r_total;    // number of bytes
    logic [47:0] r_acc;      // read/write bytes, byte 0 first
    logic        r_wr;
    logic [31:0] r_addr;

    logic [1:0]  r_status, r_pacc;
    logic [15:0] r_pnum;
    logic [7:0]  r_pwd, r_rbyte;

    // Shared adder.
    logic [31:0] w_a, w_b, w_sum;
    assign w_sum = w_a + w_b;

    // Single-port RAM.
    logic [7:0]  r_ram [RAM_BYTES];
    logic [7:0]  r_rdata;
    logic        w_inrange;
    logic        r_inrange;
    assign w_inrange = (r_addr < 32'(RAM_BYTES));
    always_ff @(posedge i_clk) begin
        if (r_state == S_MEM && w_inrange) begin
            if (r_wr) r_ram[r_addr[AW-1:0]] <= r_acc[7:0];
            r_rdata <= r_ram[r_addr[AW-1:0]];
        end
    end

    logic [31:0] w_rel;
    assign w_rel = {{24{r_imm[7]}}, r_imm[7:0]};
    logic [31:0] w_sp;
    assign w_sp = r_gr[REG_SP];

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;
    assign o_status    = r_status;
    assign o_is_halted = r_halt;
    assign o_ip_out    = r_ip;
    assign o_cs_out    = r_cs;
    assign o_zero_flag = r_flags[ZF_POS];
    assign o_port_access = r_pacc;
    assign o_port_number = r_pnum;
    assign o_port_write_data = r_pwd;
    assign o_ram_read_byte = r_rbyte;

    // Adder operand selection.
    always_comb begin
        w_a = r_ip;
        w_b = 32'(r_len);
        unique case (r_state)
            S_ADDR: begin
                // Base address and stack pointer step.
                w_a = {12'd0, r_ss, 4'd0};
                w_b = w_sp;
                if (r_req != REQ_EXEC) begin
                    w_a = 32'd0;
                    w_b = {16'd0, r_raddr};
                end else if (r_op == OP_STOSB) begin
                    w_a = {12'd0, r_es, 4'd0};
                    w_b = {16'd0, r_gr[REG_DI][15:0]};
                end else if (r_op == OP_PUSH) begin
                    w_b = w_sp - 32'd4;
                end else if (r_op == OP_INT) begin
                    w_b = w_sp - 32'd6;
                end
            end
            S_MEM, S_WAIT: begin
                w_a = r_addr;
                w_b = 32'd1;
            end
            S_FINISH: begin
                w_a = r_ip + 32'(r_len);
                w_b = w_rel;
            end
            default: ;
        endcase
    end

    // Sequencer and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int k = 0; k < 8; k++) r_gr[k] <= 32'd0;
            r_ip <= 32'd0; r_cs <= 16'd0; r_ss <= 16'd0; r_es <= 16'd0;
            r_flags <= 32'd0; r_halt <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SS:  r_ss <= i_cfg_data[15:0];
                    CFG_ES:  r_es <= i_cfg_data[15:0];
                    CFG_CS0: r_cs <= i_cfg_data[15:0];
                    CFG_IP0: r_ip <= i_cfg_data;
                    CFG_SP0: r_gr[REG_SP] <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_req_type; r_op <= i_opcode;
                        r_dvalid <= ~i_dest_register[3];
                        r_dst <= i_dest_register[2:0];
                        r_srcreg <= i_source_is_register; r_imm <= i_immediate;
                        r_len <= i_instr_length; r_pdata <= i_port_read_data;
                        r_raddr <= i_ram_address; r_wbyte <= i_ram_write_byte;
                        r_status <= ST_OK; r_pacc <= PA_NONE; r_pnum <= 16'd0;
                        r_pwd <= 8'd0; r_rbyte <= 8'd0;
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    // Decide memory work; register-only items go straight to S_FINISH.
                    r_cnt <= 4'd0;
                    r_addr <= w_sum;
                    r_wr <= 1'b0;
                    r_total <= 4'd0;
                    r_state <= S_FINISH;
                    if (r_req == REQ_WRITE) begin
                        r_wr <= 1'b1; r_acc <= {40'd0, r_wbyte};
                        r_total <= 4'd1; r_state <= S_MEM;
                    end else if (r_req == REQ_READ) begin
                        r_total <= 4'd1; r_state <= S_MEM;
                    end else if (r_req == REQ_EXEC && !r_halt && r_op <= OP_LAST) begin
                        unique case (r_op)
                            OP_STOSB: begin
                                r_wr <= 1'b1; r_acc <= {40'd0, r_gr[REG_AX][7:0]};
                                r_total <= 4'd1; r_state <= S_MEM;
                            end
                            OP_PUSH: begin
                                r_wr <= 1'b1;
                                r_acc <= {16'd0, r_dvalid ?
                                    ((r_dst == REG_SP) ? w_sp - 32'd4 : r_gr[r_dst])
                                    : 32'd0};
                                r_gr[REG_SP] <= w_sp - 32'd4;
                                r_total <= 4'd4; r_state <= S_MEM;
                            end
                            OP_POP: begin
                                r_total <= 4'd4; r_state <= S_MEM;
                            end
                            OP_RET: begin
                                r_total <= 4'd2; r_state <= S_MEM;
                            end
                            OP_IRET: begin
                                r_total <= 4'd6; r_state <= S_MEM;
                            end
                            OP_INT: begin
                                // Memory order ascending: IP, CS, FLAGS.
                                r_wr <= 1'b1;
                                r_acc <= {r_flags[15:0], r_cs, 16'(r_ip + 32'(r_len))};
                                r_gr[REG_SP] <= w_sp - 32'd6;
                                r_total <= 4'd10; r_state <= S_MEM;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MEM: begin
                    // Byte address, then S_WAIT; INT switches to the vector table after six.
                    r_inrange <= w_inrange;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (!r_wr) begin
                        r_acc <= {(r_inrange ? r_rdata : 8'd0), r_acc[47:8]};
                    end else begin
                        r_acc <= {8'd0, r_acc[47:8]};
                    end
                    r_cnt <= r_cnt + 4'd1;
                    r_addr <= w_sum;
                    if (r_op == OP_INT && r_req == REQ_EXEC && r_cnt == 4'd5) begin
                        r_wr <= 1'b0;
                        r_addr <= {22'd0, r_imm[7:0], 2'd0};
                    end
                    r_state <= (r_cnt + 4'd1 == r_total) ? S_FINISH : S_MEM;
                end
                S_FINISH: begin
                    r_state <= S_OUT;
                    if (r_req == REQ_READ) begin
                        r_rbyte <= r_acc[47:40];
                    end else if (r_req == REQ_EXEC) begin
                        if (r_halt) r_status <= ST_HALTED;
                        else if (r_op > OP_LAST) r_status <= ST_UNKNOWN;
                        else begin
                            r_ip <= r_ip + 32'(r_len);
                            unique case (r_op)
                                OP_HLT: r_halt <= 1'b1;
                                OP_IN: begin
                                    r_gr[REG_AX][7:0] <= r_pdata;
                                    r_pacc <= PA_READ; r_pnum <= r_imm[15:0];
                                end
                                OP_OUT: begin
                                    r_pacc <= PA_WRITE; r_pnum <= r_imm[15:0];
                                    r_pwd <= r_gr[REG_AX][7:0];
                                end
                                OP_MOV: if (r_dvalid && !r_srcreg) r_gr[r_dst] <= r_imm;
                                OP_POP: begin
                                    r_gr[REG_SP] <= w_sp + 32'd4;
                                    if (r_dvalid) r_gr[r_dst] <= r_acc[47:16];
                                end
                                OP_JMP: r_ip <= w_sum;
                                OP_RET: begin
                                    r_ip <= {16'd0, r_acc[47:32]};
                                    r_gr[REG_SP] <= w_sp + 32'd2;
                                end
                                OP_INT: begin
                                    r_ip <= {16'd0, r_acc[31:16]};
                                    r_cs <= r_acc[47:32];
                                end
                                OP_IRET: begin
                                    r_ip <= {16'd0, r_acc[15:0]};
                                    r_cs <= r_acc[31:16];
                                    r_flags[15:0] <= r_acc[47:32];
                                    r_gr[REG_SP] <= w_sp + 32'd6;
                                end
                                OP_STOSB: r_gr[REG_DI][15:0] <= r_gr[REG_DI][15:0] + 16'd1;
                                OP_INC: if (r_dvalid) r_gr[r_dst] <= r_gr[r_dst] + 32'd1;
                                OP_DEC: if (r_dvalid) r_gr[r_dst] <= r_gr[r_dst] - 32'd1;
                                OP_CMP: r_flags[ZF_POS] <= (r_gr[REG_AX][7:0] == r_imm[7:0]);
                                OP_JZ: if (r_flags[ZF_POS]) r_ip <= w_sum;
                                OP_JNZ: if (!r_flags[ZF_POS]) r_ip <= w_sum;
                                default: ;
                            endcase
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
